/* rtl/core/eia_pkg.sv */
// Package: operation codes, element types and shared control types of the integer ALU.
`default_nettype none
package eia_pkg;
   localparam int unsigned DataWidth = 64;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CountWidth = 7;

   typedef logic [DataWidth-1:0] data_type;
   typedef logic [4:0] op_type;
   typedef logic [2:0] etype_type;

   localparam op_type OP_ADD = 5'd0;
   localparam op_type OP_SUB = 5'd1;
   localparam op_type OP_MUL = 5'd2;
   localparam op_type OP_DIV = 5'd3;
   localparam op_type OP_POW = 5'd4;
   localparam op_type OP_MOD = 5'd5;
   localparam op_type OP_MIN = 5'd6;
   localparam op_type OP_MAX = 5'd7;
   localparam op_type OP_AND = 5'd8;
   localparam op_type OP_OR = 5'd9;
   localparam op_type OP_XOR = 5'd10;
   localparam op_type OP_SHL = 5'd11;
   localparam op_type OP_SHR = 5'd12;
   localparam op_type OP_SHRL = 5'd13;
   localparam op_type OP_EQ = 5'd14;
   localparam op_type OP_NE = 5'd15;
   localparam op_type OP_LT = 5'd16;
   localparam op_type OP_LE = 5'd17;
   localparam op_type OP_GT = 5'd18;
   localparam op_type OP_GE = 5'd19;

   localparam logic [CsrAddrWidth-1:0] CSR_OPERATION = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_ELEMENT_TYPE = 3'd4;

   // datapath commands from the controller
   typedef struct packed {
      logic load;      // capture operands and set up
      logic step;      // run one iteration of div or pow
      logic mul_lo;    // first partial product pass
      logic mul_hi;    // second partial product pass
      logic finish;    // form result register
   } dp_cmd_type;

   typedef struct packed {
      logic iterative; // operation needs the bit loop
      logic multiply;  // operation needs the multiplier
      logic loop_done; // last iteration issued
      logic pow_mul;   // pow step needs multiplies
   } dp_status_type;

   function automatic data_type width_mask(input etype_type et);
      case (et[1:0])
         2'd0: width_mask = 64'h0000_0000_0000_00ff;
         2'd1: width_mask = 64'h0000_0000_0000_ffff;
         2'd2: width_mask = 64'h0000_0000_ffff_ffff;
         default: width_mask = 64'hffff_ffff_ffff_ffff;
      endcase
   endfunction

   function automatic data_type sign_bit(input etype_type et);
      case (et[1:0])
         2'd0: sign_bit = 64'h80;
         2'd1: sign_bit = 64'h8000;
         2'd2: sign_bit = 64'h8000_0000;
         default: sign_bit = 64'h8000_0000_0000_0000;
      endcase
   endfunction
endpackage
`default_nettype wire

/* rtl/core/eia_if.sv */
// Interfaces: operand pair and result channels of the integer ALU.
`default_nettype none
interface eia_req_if;
   logic valid;
   logic ready;
   logic [63:0] lhs_value;
   logic [63:0] rhs_value;
   modport source (output valid, lhs_value, rhs_value, input ready);
   modport sink (input valid, lhs_value, rhs_value, output ready);
endinterface

interface eia_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] result_value;
   logic divide_by_zero;
   modport source (output valid, result_value, divide_by_zero, input ready);
   modport sink (input valid, result_value, divide_by_zero, output ready);
endinterface
`default_nettype wire

/* rtl/core/eia_mul.sv */
// Multiplier: 64x64 low product formed from 32-bit partial products, two of them registered on first.
`default_nettype none
module eia_mul (
   input wire logic clock,
   input wire logic first,
   input wire logic second,
   input wire logic [63:0] mul_a,
   input wire logic [63:0] mul_b,
   output logic [63:0] product
);
   import eia_pkg::*;
   logic [63:0] lo_ff, lo_in;
   logic [31:0] cross_ff, cross_in;
   logic [31:0] sum_hi;

   assign lo_in = {32'd0, mul_a[31:0]} * {32'd0, mul_b[31:0]};
   assign cross_in = mul_a[63:32] * mul_b[31:0];
   assign sum_hi = lo_ff[63:32] + cross_ff + mul_a[31:0] * mul_b[63:32];
   assign product = {sum_hi, lo_ff[31:0]};

   always_ff @(posedge clock) begin
      if (first) begin
         lo_ff <= lo_in;
         cross_ff <= cross_in;
      end
   end
   logic unused_second;
   assign unused_second = second;
endmodule
`default_nettype wire

/* rtl/core/eia_datapath.sv */
// Datapath: operand registers, divider, pow loop, simple operations and result register.
`default_nettype none
module eia_datapath (
   input wire logic clock,
   input wire eia_pkg::op_type operation,
   input wire eia_pkg::etype_type element_type,
   input wire logic [63:0] lhs_value,
   input wire logic [63:0] rhs_value,
   input wire eia_pkg::dp_cmd_type cmd,
   output eia_pkg::dp_status_type status,
   output logic [63:0] result_value,
   output logic divide_by_zero
);
   import eia_pkg::*;

   data_type mask, sbit, a, b, ka, kb;
   logic sgn, nega, negb;
   data_type a_ff, a_in, b_ff, b_in;
   data_type rem_ff, rem_in, quo_ff, quo_in;
   data_type res_ff, fac_ff, exp_ff;
   logic [CountWidth-1:0] cnt_ff;
   logic dz_ff;
   data_type out_ff, out_in;
   logic out_dz_in;
   logic nega_ff, negb_ff, pow_special_ff, pow_phase_ff;
   data_type pow_special_val_ff;
   data_type mul_a, mul_b, product;
   data_type simple;
   data_type shl_r, shr_r;
   logic big;
   logic [65:0] trial;
   logic [64:0] rem_shift;
   data_type ma, mb;

   assign mask = width_mask(element_type);
   assign sbit = sign_bit(element_type);
   assign sgn = ~element_type[2];
   assign a = lhs_value & mask;
   assign b = rhs_value & mask;
   assign nega = sgn & |(a & sbit);
   assign negb = sgn & |(b & sbit);
   assign ma = nega ? ((64'd0 - a) & mask) : a;
   assign mb = negb ? ((64'd0 - b) & mask) : b;

   assign ka = a_ff ^ (sgn ? sbit : 64'd0);
   assign kb = b_ff ^ (sgn ? sbit : 64'd0);
   assign big = (sgn & |(b_ff & sbit)) | (b_ff >= {57'd0, 7'd8 << element_type[1:0]});
   assign shl_r = big ? 64'd0 : (a_ff << b_ff[5:0]);
   always_comb begin
      if (operation == OP_SHR && (sgn & |(a_ff & sbit))) begin
         shr_r = big ? mask : ((a_ff >> b_ff[5:0]) | (~(mask >> b_ff[5:0]) & mask));
      end else begin
         shr_r = big ? 64'd0 : (a_ff >> b_ff[5:0]);
      end
   end

   always_comb begin
      case (operation)
         OP_ADD: simple = a_ff + b_ff;
         OP_SUB: simple = a_ff - b_ff;
         OP_MIN: simple = (ka < kb) ? a_ff : b_ff;
         OP_MAX: simple = (ka > kb) ? a_ff : b_ff;
         OP_AND: simple = a_ff & b_ff;
         OP_OR: simple = a_ff | b_ff;
         OP_XOR: simple = a_ff ^ b_ff;
         OP_SHL: simple = shl_r;
         OP_SHR: simple = shr_r;
         OP_SHRL: simple = shr_r;
         OP_EQ: simple = {63'd0, a_ff == b_ff};
         OP_NE: simple = {63'd0, a_ff != b_ff};
         OP_LT: simple = {63'd0, ka < kb};
         OP_LE: simple = {63'd0, ka <= kb};
         OP_GT: simple = {63'd0, ka > kb};
         OP_GE: simple = {63'd0, ka >= kb};
         default: simple = 64'd0;
      endcase
   end

   // restoring divider on magnitudes, one quotient bit per step
   assign rem_shift = {rem_ff, a_ff[63]};
   assign trial = {1'b0, rem_shift} - {2'b0, b_ff};

   always_comb begin
      mul_a = fac_ff;
      mul_b = fac_ff;
      if (operation == OP_MUL) begin
         mul_a = a_ff;
         mul_b = b_ff;
      end else if (!pow_phase_ff) begin
         mul_a = res_ff;
      end
   end

   eia_mul u_mul (
      .clock(clock),
      .first(cmd.mul_lo),
      .second(cmd.mul_hi),
      .mul_a(mul_a),
      .mul_b(mul_b),
      .product(product)
   );

   assign status.iterative = (operation == OP_DIV) | (operation == OP_MOD) |
                             (operation == OP_POW);
   assign status.multiply = (operation == OP_MUL);
   assign status.loop_done = (operation == OP_POW) ? ((exp_ff == 64'd0) | pow_special_ff)
                                                   : (cnt_ff == 7'd0);
   assign status.pow_mul = (operation == OP_POW) & ~pow_special_ff & (exp_ff != 64'd0);

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.load) begin
         if (operation == OP_DIV || operation == OP_MOD) begin
            a_in = ma;
            b_in = mb;
         end else begin
            a_in = a;
            b_in = b;
         end
         rem_in = 64'd0;
         quo_in = 64'd0;
      end else if (cmd.step && operation != OP_POW) begin
         a_in = {a_ff[62:0], 1'b0};
         if (!trial[65]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_shift[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end
   end

   always_comb begin
      out_dz_in = 1'b0;
      case (operation)
         OP_DIV: begin
            out_in = (nega_ff != negb_ff) ? (64'd0 - quo_ff) : quo_ff;
            if (dz_ff) begin
               out_in = 64'd0;
               out_dz_in = 1'b1;
            end
         end
         OP_MOD: begin
            out_in = nega_ff ? (64'd0 - rem_ff) : rem_ff;
            if (dz_ff) begin
               out_in = 64'd0;
               out_dz_in = 1'b1;
            end
         end
         OP_POW: out_in = pow_special_ff ? pow_special_val_ff : res_ff;
         OP_MUL: out_in = product;
         default: out_in = simple;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load) begin
         cnt_ff <= 7'd64;
         dz_ff <= (b == 64'd0);
         nega_ff <= nega;
         negb_ff <= negb;
         res_ff <= 64'd1;
         fac_ff <= a;
         exp_ff <= b;
         pow_phase_ff <= 1'b0;
         pow_special_ff <= negb;
         if (a == 64'd1) begin
            pow_special_val_ff <= 64'd1;
         end else if (a == mask) begin
            pow_special_val_ff <= b[0] ? mask : 64'd1;
         end else begin
            pow_special_val_ff <= 64'd0;
         end
      end else if (cmd.step) begin
         if (operation == OP_POW) begin
            if (!pow_phase_ff) begin
               if (exp_ff[0]) begin
                  res_ff <= product & mask;
               end
            end else begin
               fac_ff <= product & mask;
               exp_ff <= exp_ff >> 1;
            end
            pow_phase_ff <= ~pow_phase_ff;
         end else begin
            cnt_ff <= cnt_ff - 7'd1;
         end
      end
      if (cmd.finish) begin
         out_ff <= out_in & mask;
         divide_by_zero <= out_dz_in;
      end
   end
   assign result_value = out_ff;
endmodule
`default_nettype wire

/* rtl/core/eia_ctrl.sv */
// Controller: sequences load, loop steps, multiplies and result handoff.
`default_nettype none
module eia_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input wire eia_pkg::dp_status_type status,
   output eia_pkg::dp_cmd_type cmd
);
   import eia_pkg::*;
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_LOAD = 6'b000010,
      S_LOOP = 6'b000100,
      S_MULA = 6'b001000,
      S_MULB = 6'b010000,
      S_FIN = 6'b100000
   } state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid & req_ready) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (status.multiply) begin
               state_in = S_MULA;
            end else if (status.iterative) begin
               state_in = S_LOOP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_LOOP: begin
            if (status.loop_done) begin
               state_in = S_FIN;
            end else if (status.pow_mul) begin
               state_in = S_MULA;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_MULA: begin
            cmd.mul_lo = 1'b1;
            state_in = S_MULB;
         end
         S_MULB: begin
            cmd.mul_hi = 1'b1;
            if (status.multiply) begin
               state_in = S_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = S_LOOP;
            end
         end
         S_FIN: begin
            // hold until the result slot is free or is being taken
            if (~rsp_valid_ff | rsp_ready) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/elementwise_integer_alu.sv */
// Top level: integer ALU with APB-style register port, controller and datapath.
//
//  channel  direction  handshake        payload
//  req      in         valid/ready      lhs_value, rhs_value
//  rsp      out        valid/ready      result_value, divide_by_zero
//  csr      in         psel/penable     operation, element_type
//
// Simple operations go from accept through S_LOAD and S_FIN to the result; mul adds S_MULA and S_MULB.
// Div and mod run the loop of the restoring divider, one quotient bit per cycle.
// Pow runs the loop with two multiplies per exponent bit on the shared multiplier.
// Reset clears the CSR registers and the controller; a stalled result holds the next item
// in S_FIN.
`default_nettype none
module elementwise_integer_alu (
   input wire logic clock,
   input wire logic reset,
   eia_req_if.sink req,
   eia_rsp_if.source rsp,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [eia_pkg::CsrAddrWidth-1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import eia_pkg::*;
   op_type operation_ff;
   etype_type element_type_ff;
   dp_cmd_type cmd;
   dp_status_type status;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= OP_ADD;
         element_type_ff <= 3'd0;
      end else if (wr) begin
         case (csr_paddr)
            CSR_OPERATION: operation_ff <= csr_pwdata[4:0];
            CSR_ELEMENT_TYPE: element_type_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr)
         CSR_OPERATION: csr_prdata = {27'd0, operation_ff};
         CSR_ELEMENT_TYPE: csr_prdata = {29'd0, element_type_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   eia_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .status(status),
      .cmd(cmd)
   );

   eia_datapath u_dp (
      .clock(clock),
      .operation(operation_ff),
      .element_type(element_type_ff),
      .lhs_value(req.lhs_value),
      .rhs_value(req.rhs_value),
      .cmd(cmd),
      .status(status),
      .result_value(rsp.result_value),
      .divide_by_zero(rsp.divide_by_zero)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req.valid & req.ready) |=> !req.ready)
      else $error("accepted a second item while busy");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp.valid)
      else $error("finished item not presented");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.finish}))
      else $error("conflicting datapath commands");
endmodule
`default_nettype wire
